/* rtl/ordered_list_insert_search_remove_assert.svh */
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shared property forms for the ordered list block, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_SEARCH_REMOVE_ASSERT_SVH
`define ORDERED_LIST_INSERT_SEARCH_REMOVE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define OLISR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define OLISR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/olisr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list package
// Operation codes, widths and the command bundle broadcast to the cell row.
// ----------------------------------------------------------------------------
package olisr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VALUE_W   = 32;
  localparam int FUNC_W    = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_FRONT = 2'd0,
    FUNC_INS_BACK  = 2'd1,
    FUNC_SEARCH    = 2'd2,
    FUNC_REMOVE    = 2'd3
  } func_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic  capture;  // latch compare result for the incoming beat
    logic  apply;    // perform the update for the pending operation
    func_t func;
    logic  full;
  } cell_cmd_t;

endpackage

/* rtl/olisr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list position, compares it against the incoming value and
// takes data from its left or right neighbor on a shift, or the new value at the tail.
// ----------------------------------------------------------------------------
module olisr_cell
  import olisr_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]   count,
  input  logic [VALUE_W-1:0] cmp_value,
  input  logic [VALUE_W-1:0] wr_value,
  input  logic [VALUE_W-1:0] left_data,
  input  logic [VALUE_W-1:0] right_data,
  input  logic               seen_in,
  output logic [VALUE_W-1:0] data,
  output logic               match,
  output logic               seen_out
);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;
  logic               match_r;
  logic               match_nxt;
  logic               occupied;
  logic               tail_slot;

  assign occupied  = CNT_W'(IDX) < count;
  assign tail_slot = CNT_W'(IDX) == count;

  // Pass the first-match mark down the row
  assign seen_out = seen_in | match_r;

  // Latch the compare result when a beat is accepted
  assign match_nxt = cmd.capture ? (occupied && (data_r == cmp_value)) : match_r;

  // Select the new content for this position
  always_comb begin
    data_nxt = data_r;
    if (cmd.apply) begin
      unique case (cmd.func)
        FUNC_INS_FRONT: begin
          if (!cmd.full) data_nxt = left_data;
        end
        FUNC_INS_BACK: begin
          if (!cmd.full && tail_slot) data_nxt = wr_value;
        end
        FUNC_REMOVE: begin
          if (seen_out) data_nxt = right_data;
        end
        default: begin
          data_nxt = data_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

/* rtl/ordered_list_insert_search_remove.sv */
`timescale 1ns / 1ps
// The result beat is registered when the apply state completes, which follows the accept;
// the apply waits while the previous result beat is still held by out_stall.
// One item at a time: the cells compare in the accept cycle and
// update (shift or write) in the apply state, one pass over the cell row per item.
// Reset clears the entry count and the output valid; cell contents are not cleared
// and are only read below the entry count.
// ----------------------------------------------------------------------------
// Ordered list with insert, search and remove
// A row of DEPTH cells holds the list head first. Inserts at the front shift
// the row right, removes close the gap by shifting left from the first match.
// ----------------------------------------------------------------------------
module ordered_list_insert_search_remove
  import olisr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic                      out_status,
  output logic [COUNT_W-1:0]        out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  state_t             state_r, state_nxt;
  func_t              func_r, func_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_status_r, out_status_nxt;
  logic [COUNT_W-1:0] out_entry_count_r, out_entry_count_nxt;

  logic               in_accept;
  logic               apply_go;
  logic               full;
  logic               match_any;
  logic               is_insert;
  logic [EW-1:0]      count_ext;
  cell_cmd_t          cmd;

  logic               apply_st;
  logic               ins_refused;
  logic               rm_hit;

  logic [VALUE_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]   match_vec;
  logic [DEPTH-1:0]   seen_vec;

  // Handshake: one item in flight at a time
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign apply_go  = (state_r == ST_APPLY) && !(out_valid_r && out_stall);

  assign full      = (count_r == CW'(DEPTH));
  assign match_any = |match_vec;
  assign is_insert = (func_r == FUNC_INS_FRONT) || (func_r == FUNC_INS_BACK);

  // Broadcast command to the row
  always_comb begin
    cmd.capture = in_accept;
    cmd.apply   = apply_go;
    cmd.func    = func_r;
    cmd.full    = full;
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_data;
    logic [VALUE_W-1:0] right_data;
    logic               seen_in;

    if (i == 0) begin : g_head
      assign left_data = value_r;
      assign seen_in   = 1'b0;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign seen_in   = seen_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    olisr_cell #(
      .CNT_W (CW),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .cmp_value  (in_value),
      .wr_value   (value_r),
      .left_data  (left_data),
      .right_data (right_data),
      .seen_in    (seen_in),
      .data       (cell_data[i]),
      .match      (match_vec[i]),
      .seen_out   (seen_vec[i])
    );
  end

  // Compute the count after the pending operation
  always_comb begin
    count_nxt = count_r;
    unique case (func_r)
      FUNC_INS_FRONT, FUNC_INS_BACK: begin
        if (!full) count_nxt = count_r + CW'(1);
      end
      FUNC_REMOVE: begin
        if (match_any) count_nxt = count_r - CW'(1);
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign count_ext = EW'(count_nxt);

  // Next state, pending operation and result beat
  always_comb begin
    state_nxt           = state_r;
    func_nxt            = func_r;
    value_nxt           = value_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_hit_nxt         = out_hit_r;
    out_status_nxt      = out_status_r;
    out_entry_count_nxt = out_entry_count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          func_nxt  = func_t'(in_func);
          value_nxt = in_value;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          out_valid_nxt       = 1'b1;
          out_hit_nxt         = !is_insert && match_any;
          out_status_nxt      = is_insert && full;
          out_entry_count_nxt = count_ext[COUNT_W-1:0];
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, count and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply_go) count_r <= count_nxt;
    end
    func_r            <= func_nxt;
    value_r           <= value_nxt;
    out_hit_r         <= out_hit_nxt;
    out_status_r      <= out_status_nxt;
    out_entry_count_r <= out_entry_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_entry_count_r;

  // Checks
`include "ordered_list_insert_search_remove_assert.svh"

  assign apply_st    = (state_r == ST_APPLY);
  assign ins_refused = apply_go && is_insert && full;
  assign rm_hit      = apply_go && (func_r == FUNC_REMOVE) && match_any;

  `OLISR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "entry count above depth")
  `OLISR_ASSERT_NEXT(a_full_hold, ins_refused, $stable(count_r), "refused insert changed count")
  `OLISR_ASSERT_NEXT(a_remove_dec, rm_hit, count_r == $past(count_r) - CW'(1), "remove kept count")
  `OLISR_ASSERT_NOW(a_out_src, $rose(out_valid_r), $past(apply_st), "result beat without apply")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list testbench
// Drives insert, search and remove beats into the ordered list and checks
// every result beat against a queue-based model of the list. A directed table
// covers the empty and full cases, the value extremes and duplicates, then a
// long random run mixes insert-heavy and remove-heavy stretches with random
// idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import olisr_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RAND_ITEMS   = 625;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SQUEEZE_HOLD = 150;

  typedef struct packed {
    logic               hit;
    logic               status;
    logic [COUNT_W-1:0] count;
  } op_result_t;

  typedef struct {
    func_t              op;
    logic [VALUE_W-1:0] value;
    bit                 known;
    op_result_t         res;
  } op_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [FUNC_W-1:0]         in_func = FUNC_INS_FRONT;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_hit;
  logic                      out_status;
  logic [COUNT_W-1:0]        out_entry_count;

  // typed-in result for the beat on the input, when the table gives one
  logic       row_known = 1'b0;
  op_result_t row_result = '0;

  logic [VALUE_W-1:0] list_image[$];
  op_row_t            pending_results[$];
  op_row_t            op_table[$];
  int                 fail_count = 0;
  int                 cycle_count = 0;
  bit                 squeeze_req = 1'b0;

  ordered_list_insert_search_remove dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one operation to the list image and return its result
  function automatic op_result_t apply_list_op(func_t op, logic [VALUE_W-1:0] v);
    op_result_t r;
    int         at;
    r  = '0;
    at = -1;
    foreach (list_image[i])
      if (at < 0 && list_image[i] == v) at = i;
    case (op)
      FUNC_INS_FRONT, FUNC_INS_BACK: begin
        if (list_image.size() >= LIST_DEPTH) r.status = 1'b1;
        else if (op == FUNC_INS_FRONT) list_image.push_front(v);
        else list_image.push_back(v);
      end
      FUNC_SEARCH: r.hit = (at >= 0);
      FUNC_REMOVE: begin
        if (at >= 0) begin
          list_image.delete(at);
          r.hit = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(list_image.size());
    return r;
  endfunction

  // Gap before a beat: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Value: often one already stored, else a corner value or fully random
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && list_image.size() > 0)
      return list_image[$urandom_range(0, list_image.size() - 1)];
    if (r < 70) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        4: return 32'h0000_0005;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(func_t op, logic [VALUE_W-1:0] v, bit known,
                         logic hit, logic status, int count);
    op_row_t row;
    row.op     = op;
    row.value  = v;
    row.known  = known;
    row.res    = '{hit, status, COUNT_W'(count)};
    op_table.push_back(row);
  endtask

  // Present one beat and hold it until accepted
  task automatic send_item(op_row_t row, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= row.op;
    in_value   <= row.value;
    row_known  <= row.known;
    row_result <= row.res;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Check result beats, then record accepted beats
  always @(posedge clk) begin
    op_row_t    exp_row;
    op_row_t    acc_row;
    op_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_hit, out_status, out_entry_count};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: hit=%0d status=%0d count=%0d",
                   got.hit, got.status, got.count);
      end else begin
        exp_row = pending_results.pop_front();
        if (got !== exp_row.res) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch %s %h: expected hit=%0d status=%0d count=%0d, got hit=%0d status=%0d count=%0d",
                     exp_row.op.name(), exp_row.value, exp_row.res.hit,
                     exp_row.res.status, exp_row.res.count, got.hit, got.status,
                     got.count);
        end
      end
    end
    if (rst_n && in_valid && in_stall === 1'b0) begin
      acc_row.op    = func_t'(in_func);
      acc_row.value = in_value;
      acc_row.known = row_known;
      acc_row.res   = apply_list_op(acc_row.op, acc_row.value);
      if (row_known) acc_row.res = row_result;
      pending_results.push_back(acc_row);
    end
  end

  // Result side stall: calm stretches, random stalls, long holds
  initial begin
    int run_left;
    int hold_left;
    int r;
    bit calm;
    bit squeezed;
    run_left  = 0;
    hold_left = 0;
    calm      = 1'b0;
    squeezed  = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          calm     = ($urandom_range(0, 2) == 0);
          run_left = $urandom_range(20, 80);
        end
        run_left--;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          if (r >= 97) hold_left = $urandom_range(8, 40);
        end
      end
    end
  end

  // Bound the run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin
    op_row_t row;
    int      ins_weight;
    int      r;
    bit      calm;

    // empty list, extremes, then fill to full with duplicates of 5
    add_row(FUNC_SEARCH,    32'h0000_0000, 1, 0, 0, 0);
    add_row(FUNC_REMOVE,    32'h0000_0000, 1, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'h7FFF_FFFF, 1, 0, 0, 1);
    add_row(FUNC_INS_BACK,  32'h8000_0000, 1, 0, 0, 2);
    add_row(FUNC_SEARCH,    32'h7FFF_FFFF, 0, 0, 0, 0);
    add_row(FUNC_SEARCH,    32'h8000_0000, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'h0000_0005, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'h0000_0005, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'h0000_0000, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'h5555_5555, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'hAAAA_AAAA, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'h0000_0005, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'h0000_0001, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'h8000_0001, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'h7FFF_FFFE, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'h1234_5678, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'hFEDC_BA98, 0, 0, 0, 0);
    add_row(FUNC_INS_BACK,  32'h0F0F_0F0F, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'hF0F0_F0F0, 0, 0, 0, 0);
    add_row(FUNC_INS_FRONT, 32'h0000_0002, 1, 0, 1, LIST_DEPTH);
    add_row(FUNC_INS_BACK,  32'h0000_0003, 1, 0, 1, LIST_DEPTH);
    add_row(FUNC_REMOVE,    32'h0000_0005, 0, 0, 0, 0);
    add_row(FUNC_REMOVE,    32'h0000_3039, 0, 0, 0, 0);
    add_row(FUNC_SEARCH,    32'h0000_0005, 0, 0, 0, 0);

    // hold reset, release on an edge
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (op_table[i]) send_item(op_table[i], pick_gap());

    ins_weight = 50;
    calm       = 1'b0;
    row.known  = 1'b0;
    row.res    = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // new stretch: shift the insert mix to sweep the fill level
      if (n % 50 == 0) begin
        ins_weight = $urandom_range(15, 85);
        calm       = ($urandom_range(0, 3) == 0);
      end
      // let all pending result beats drain before continuing
      if (n == 400) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      if (n == 200) squeeze_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < ins_weight) row.op = ($urandom_range(0, 1) != 0) ? FUNC_INS_FRONT : FUNC_INS_BACK;
      else row.op = ($urandom_range(0, 1) != 0) ? FUNC_SEARCH : FUNC_REMOVE;
      row.value = pick_value();
      send_item(row, (calm || n == 400 || (n >= 200 && n < 240)) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
